>>> rtl/sbfc_pkg.sv
// ----------------------------------------------------------------------------
// sbfc_pkg
// Shared types and constants for the slot bitmap fill/clear block.
// ----------------------------------------------------------------------------
package sbfc_pkg;

	localparam int unsigned WORD_BITS = 32;
	localparam int unsigned CNT_W     = 11;
	localparam int unsigned POS_W     = 10;

	typedef enum logic {
		OP_FILL  = 1'b0,
		OP_CLEAR = 1'b1
	} sbfc_op_t;

	typedef enum logic [1:0] {
		ST_WIPE,
		ST_IDLE,
		ST_SCAN,
		ST_DONE
	} sbfc_state_t;

	typedef struct packed {
		logic             op;
		logic [POS_W-1:0] first_slot;
		logic [CNT_W-1:0] fill_count;
		logic [POS_W-1:0] last_slot;
	} sbfc_cmd_t;

	typedef struct packed {
		logic             none_placed;
		logic [POS_W-1:0] first_placed;
		logic [POS_W-1:0] last_placed;
		logic [CNT_W-1:0] freed_count;
	} sbfc_result_t;

	// per-word update request and outcome
	typedef struct packed {
		logic [WORD_BITS-1:0] word;
		logic [4:0]           lo_bit;
		logic [4:0]           hi_bit;
		sbfc_op_t             op;
		logic [CNT_W-1:0]     want;
	} sbfc_word_req_t;

	typedef struct packed {
		logic [WORD_BITS-1:0] word;
		logic                 any;
		logic [4:0]           lo_idx;
		logic [4:0]           hi_idx;
		logic [5:0]           count;
	} sbfc_word_res_t;

endpackage

>>> rtl/sbfc_mem.sv
// ----------------------------------------------------------------------------
// sbfc_mem
// Bitmap word store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module sbfc_mem
	import sbfc_pkg::*;
#(
	parameter int unsigned WORDS = 32,
	parameter int unsigned AW    = 5
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [AW-1:0]        waddr,
	input  logic [WORD_BITS-1:0] wdata,
	input  logic                 re,
	input  logic [AW-1:0]        raddr,
	output logic [WORD_BITS-1:0] rdata
);

	logic [WORD_BITS-1:0] mem [WORDS];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> rtl/sbfc_word_op.sv
// ----------------------------------------------------------------------------
// sbfc_word_op
// Read-modify step on one 32-bit bitmap word: fill lowest free bits up to
// the remaining count, or clear a bit range, with counts and bit indexes.
// ----------------------------------------------------------------------------
module sbfc_word_op
	import sbfc_pkg::*;
(
	input  sbfc_word_req_t req,
	output sbfc_word_res_t res
);

	logic [WORD_BITS-1:0] mask;
	logic [WORD_BITS-1:0] cand;
	logic [WORD_BITS-1:0] sel;
	logic [5:0]           pre [6][WORD_BITS];
	logic [5:0]           total;

	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			mask[j] = (5'(j) >= req.lo_bit) && (5'(j) <= req.hi_bit);
		end
		cand = (req.op == OP_CLEAR) ? (req.word & mask) : (~req.word & mask);
	end

	// log-depth prefix count of candidate bits
	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			pre[0][j] = {5'd0, cand[j]};
		end
		for (int l = 0; l < 5; l++) begin
			for (int j = 0; j < WORD_BITS; j++) begin
				if (j >= (1 << l)) begin
					pre[l+1][j] = pre[l][j] + pre[l][j - (1 << l)];
				end else begin
					pre[l+1][j] = pre[l][j];
				end
			end
		end
		total = pre[5][WORD_BITS-1];
	end

	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			sel[j] = cand[j] && ((req.op == OP_CLEAR) || (CNT_W'(pre[5][j]) <= req.want));
		end
	end

	always_comb begin
		res = '0;
		res.word = (req.op == OP_CLEAR) ? (req.word & ~sel) : (req.word | sel);
		res.any  = |sel;
		if (req.op == OP_CLEAR || CNT_W'(total) <= req.want) begin
			res.count = total;
		end else begin
			res.count = 6'(req.want);
		end
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (sel[j]) begin
				res.lo_idx = 5'(j);
			end
		end
		for (int j = 0; j < WORD_BITS; j++) begin
			if (sel[j]) begin
				res.hi_idx = 5'(j);
			end
		end
	end

endmodule

>>> rtl/slot_bitmap_fill_and_clear.sv
// ----------------------------------------------------------------------------
// slot_bitmap_fill_and_clear
// Occupancy bitmap over SLOTS slots, stored as 32-bit words in one memory.
// Fill occupies free slots upward from a start position; clear frees a range
// and counts the occupied slots it freed.
//
//   channel   ports                    transfer when
//   command   start, busy, cmd         start && !busy
//   result    done, result             done (one cycle, no back-pressure)
//   config    cfg_we, cfg_wdata        cfg_we
//
// One word is read per cycle, modified and written back as the data returns
// from the registered read. A fill stops at the word where the count runs
// out. Zero-count fills and reversed clear ranges report on the next cycle.
// After reset, busy stays high while memory is cleared one word per cycle.
// busy is low during done, so the next command can transfer in that cycle.
// ----------------------------------------------------------------------------
module slot_bitmap_fill_and_clear
	import sbfc_pkg::*;
#(
	parameter int unsigned SLOTS = 1024
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  sbfc_cmd_t        cmd,
	output logic             done,
	output sbfc_result_t     result,
	input  logic             cfg_we,
	input  logic [CNT_W-1:0] cfg_wdata
);

	localparam int unsigned WORDS = (SLOTS + WORD_BITS - 1) / WORD_BITS;
	localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int unsigned PW    = $clog2(SLOTS);
	localparam int unsigned NW    = $clog2(SLOTS + 1);
	localparam int unsigned CW    = (NW > CNT_W) ? NW : CNT_W;

	sbfc_state_t state_q, state_d;

	logic [CNT_W-1:0] slot_count_q;
	sbfc_op_t         op_q;
	logic [PW-1:0]    start_q, end_q, lo_q, hi_q;
	logic [CNT_W-1:0] want_q, freed_q;
	logic             any_q, rd_more_q;
	logic [AW-1:0]    rd_ptr_q, wipe_q;
	logic             valid_s1;
	logic [AW-1:0]    addr_s1;

	logic                 accept;
	logic [CW-1:0]        n_eff;
	logic [PW-1:0]        first_c, last_c;
	logic [AW-1:0]        start_word, end_word;
	logic                 rd_en, wr_en;
	logic [AW-1:0]        wr_addr;
	logic [WORD_BITS-1:0] wr_data, rdata;
	logic                 process, finish;
	sbfc_word_req_t       wreq;
	sbfc_word_res_t       wres;

	sbfc_mem #(
		.WORDS(WORDS),
		.AW   (AW)
	) u_mem (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(wr_data),
		.re   (rd_en),
		.raddr(rd_ptr_q),
		.rdata(rdata)
	);

	sbfc_word_op u_word_op (
		.req(wreq),
		.res(wres)
	);

	// command decode: effective count and saturated positions
	always_comb begin
		if (slot_count_q == '0) begin
			n_eff = CW'(1);
		end else if (CW'(slot_count_q) > CW'(SLOTS)) begin
			n_eff = CW'(SLOTS);
		end else begin
			n_eff = CW'(slot_count_q);
		end
		first_c = (CW'(cmd.first_slot) >= n_eff) ? PW'(n_eff - CW'(1)) : PW'(cmd.first_slot);
		last_c  = (CW'(cmd.last_slot) >= n_eff) ? PW'(n_eff - CW'(1)) : PW'(cmd.last_slot);
	end

	assign start_word = AW'(start_q >> 5);
	assign end_word   = AW'(end_q >> 5);

	assign busy   = (state_q == ST_WIPE) || (state_q == ST_SCAN);
	assign accept = start && !busy;
	assign rd_en  = (state_q == ST_SCAN) && rd_more_q;

	always_comb begin
		wreq        = '0;
		wreq.word   = rdata;
		wreq.lo_bit = (addr_s1 == start_word) ? 5'(start_q) : 5'd0;
		wreq.hi_bit = (addr_s1 == end_word) ? 5'(end_q) : 5'd31;
		wreq.op     = op_q;
		wreq.want   = want_q;
	end

	assign process = (state_q == ST_SCAN) && valid_s1;
	assign finish  = process && ((addr_s1 == end_word) ||
		((op_q == OP_FILL) && (want_q == CNT_W'(wres.count))));

	always_comb begin
		state_d = state_q;
		wr_en   = 1'b0;
		wr_addr = addr_s1;
		wr_data = wres.word;
		unique case (state_q)
			ST_WIPE: begin
				wr_en   = 1'b1;
				wr_addr = wipe_q;
				wr_data = '0;
				if (wipe_q == AW'(WORDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE, ST_DONE: begin
				if (accept) begin
					if ((sbfc_op_t'(cmd.op) == OP_FILL && cmd.fill_count == '0) ||
						(sbfc_op_t'(cmd.op) == OP_CLEAR && first_c > last_c)) begin
						state_d = ST_DONE;
					end else begin
						state_d = ST_SCAN;
					end
				end else begin
					state_d = ST_IDLE;
				end
			end
			ST_SCAN: begin
				wr_en = process;
				if (finish) begin
					state_d = ST_DONE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_WIPE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_count_q <= CNT_W'(1024);
			wipe_q       <= '0;
			rd_more_q    <= 1'b0;
			valid_s1     <= 1'b0;
			any_q        <= 1'b0;
			op_q         <= OP_FILL;
		end else begin
			if (cfg_we) begin
				slot_count_q <= cfg_wdata;
			end
			if (state_q == ST_WIPE) begin
				wipe_q <= wipe_q + AW'(1);
			end
			valid_s1 <= rd_en;
			if (accept) begin
				op_q      <= sbfc_op_t'(cmd.op);
				rd_more_q <= 1'b1;
				any_q     <= 1'b0;
			end else if (finish) begin
				rd_more_q <= 1'b0;
			end else if (rd_en && rd_ptr_q == end_word) begin
				rd_more_q <= 1'b0;
			end
			if (process && wres.any) begin
				any_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			addr_s1 <= rd_ptr_q;
		end
		if (accept) begin
			start_q  <= first_c;
			end_q    <= (sbfc_op_t'(cmd.op) == OP_FILL) ? PW'(n_eff - CW'(1)) : last_c;
			want_q   <= cmd.fill_count;
			freed_q  <= '0;
			rd_ptr_q <= AW'(first_c >> 5);
		end else begin
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + AW'(1);
			end
			if (process) begin
				want_q  <= want_q - CNT_W'(wres.count);
				freed_q <= freed_q + CNT_W'(wres.count);
				if (wres.any) begin
					hi_q <= PW'({addr_s1, wres.hi_idx});
					if (!any_q) begin
						lo_q <= PW'({addr_s1, wres.lo_idx});
					end
				end
			end
		end
	end

	assign done = (state_q == ST_DONE);

	always_comb begin
		result = '0;
		if (op_q == OP_FILL) begin
			result.none_placed = !any_q;
			if (any_q) begin
				result.first_placed = POS_W'(lo_q);
				result.last_placed  = POS_W'(hi_q);
			end
		end else begin
			result.freed_count = freed_q;
		end
	end

	a_no_rw_same_word: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && rd_en) |-> (wr_addr != rd_ptr_q))
		else $error("read and write of the same word in one cycle");

	a_wr_only_active: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> (state_q == ST_WIPE || state_q == ST_SCAN))
		else $error("memory write outside wipe or scan");

	a_want_monotonic: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && $past(state_q) == ST_SCAN && op_q == OP_FILL) |->
		(want_q <= $past(want_q)))
		else $error("remaining fill count grew during scan");

	a_done_after_work: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> ($past(state_q) == ST_SCAN || $past(accept)))
		else $error("result strobe without a transfer or scan");

	a_no_read_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && $past(accept)) |-> !valid_s1)
		else $error("stale read data at start of scan");

endmodule

>>> tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for slot_bitmap_fill_and_clear. Commands go in through
// the start/busy handshake while an in-bench occupancy model predicts each
// result; a monitor compares every done strobe against the oldest
// prediction. Covers directed corner cases, slot count register extremes,
// random fill/clear traffic at several idle ratios and a full drain pause.
// ----------------------------------------------------------------------------
module tb;
	import sbfc_pkg::*;

	localparam int SLOT_MAX     = 1024;
	localparam int STALL_LIMIT  = 2000;
	localparam int DRAIN_CYCLES = 40;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	sbfc_cmd_t        cmd;
	logic             done;
	sbfc_result_t     result;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	bit               occupied [SLOT_MAX];
	logic [CNT_W-1:0] slot_count_reg;
	sbfc_result_t     pending_results [$];
	sbfc_result_t     oldest_result;
	int               errors;
	int               fills_sent;
	int               clears_sent;
	int               results_seen;
	int               cfg_writes;
	int               idle_pct;
	int               quiet_cycles;

	slot_bitmap_fill_and_clear #(
		.SLOTS(SLOT_MAX)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.result   (result),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	function automatic int active_slots();
		if (slot_count_reg == 0)
			return 1;
		if (slot_count_reg > SLOT_MAX)
			return SLOT_MAX;
		return slot_count_reg;
	endfunction

	// updates the occupancy model and returns the result the command should give
	function automatic sbfc_result_t occupy_or_free(sbfc_cmd_t c);
		int           n;
		int           start_pos;
		int           end_pos;
		int           want;
		int           freed;
		bit           any;
		sbfc_result_t r;
		n         = active_slots();
		start_pos = (c.first_slot >= n) ? n - 1 : c.first_slot;
		end_pos   = (c.last_slot >= n) ? n - 1 : c.last_slot;
		r         = '0;
		if (c.op == OP_FILL) begin
			want = c.fill_count;
			any  = 1'b0;
			for (int i = start_pos; i < n && want > 0; i++) begin
				if (!occupied[i]) begin
					occupied[i] = 1'b1;
					if (!any)
						r.first_placed = i;
					r.last_placed = i;
					any           = 1'b1;
					want--;
				end
			end
			r.none_placed = !any;
		end else begin
			freed = 0;
			for (int i = start_pos; i <= end_pos; i++) begin
				if (occupied[i]) begin
					occupied[i] = 1'b0;
					freed++;
				end
			end
			r.freed_count = freed;
		end
		return r;
	endfunction

	function automatic sbfc_cmd_t make_cmd(sbfc_op_t op, int first, int count, int last);
		sbfc_cmd_t c;
		c.op         = op;
		c.first_slot = first;
		c.fill_count = count;
		c.last_slot  = last;
		return c;
	endfunction

	function automatic sbfc_cmd_t random_cmd();
		sbfc_cmd_t c;
		int        n;
		int        last;
		n = active_slots();
		c = $urandom;
		if ($urandom_range(99) < 15)
			return c;
		c.op         = ($urandom_range(99) < 55) ? OP_FILL : OP_CLEAR;
		c.first_slot = $urandom_range(n - 1);
		if (c.op == OP_FILL) begin
			if ($urandom_range(9) == 0)
				c.fill_count = $urandom_range(2047);
			else
				c.fill_count = $urandom_range(n / 4 + 1);
		end else if ($urandom_range(9) != 0) begin
			last        = c.first_slot + $urandom_range(n / 3);
			c.last_slot = (last > SLOT_MAX - 1) ? SLOT_MAX - 1 : last;
		end
		return c;
	endfunction

	// leaves start high after the transfer, unless an idle gap is drawn, so back-to-back commands need no gap
	task automatic send_cmd(input sbfc_cmd_t c);
		start <= 1'b1;
		cmd   <= c;
		do
			@(posedge clk);
		while (busy);
		pending_results.push_back(occupy_or_free(c));
		if (c.op == OP_FILL)
			fills_sent++;
		else
			clears_sent++;
		if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
	endtask

	task automatic drain_results();
		start <= 1'b0;
		do
			@(posedge clk);
		while (pending_results.size() != 0 || busy);
	endtask

	task automatic write_slot_count(input logic [CNT_W-1:0] value);
		drain_results();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		slot_count_reg = value;
		cfg_we <= 1'b0;
		cfg_writes++;
	endtask

	task automatic test_directed_ops();
		idle_pct = 0;
		write_slot_count(11'd1024);
		send_cmd(make_cmd(OP_FILL, 0, 0, 1023));
		send_cmd(make_cmd(OP_FILL, 0, 1, 0));
		send_cmd(make_cmd(OP_FILL, 1023, 1024, 0));
		send_cmd(make_cmd(OP_FILL, 1023, 1, 512));
		send_cmd(make_cmd(OP_FILL, 0, 2047, 1023));
		send_cmd(make_cmd(OP_FILL, 0, 5, 0));
		send_cmd(make_cmd(OP_CLEAR, 0, 2047, 1023));
		send_cmd(make_cmd(OP_CLEAR, 0, 0, 1023));
		send_cmd(make_cmd(OP_FILL, 500, 1024, 0));
		send_cmd(make_cmd(OP_CLEAR, 1023, 7, 0));
		send_cmd(make_cmd(OP_CLEAR, 600, 0, 600));
		send_cmd(make_cmd(OP_FILL, 0, 3, 1023));
		send_cmd(make_cmd(OP_FILL, 598, 3, 0));
		send_cmd(make_cmd(OP_CLEAR, 0, 1024, 1023));
	endtask

	task automatic test_count_register();
		idle_pct = 0;
		write_slot_count(11'd0);
		send_cmd(make_cmd(OP_FILL, 1023, 3, 0));
		send_cmd(make_cmd(OP_FILL, 0, 1, 0));
		send_cmd(make_cmd(OP_CLEAR, 5, 0, 9));
		write_slot_count(11'd2047);
		send_cmd(make_cmd(OP_FILL, 1020, 10, 0));
		write_slot_count(11'd100);
		send_cmd(make_cmd(OP_CLEAR, 0, 0, 1023));
		send_cmd(make_cmd(OP_FILL, 95, 10, 0));
		write_slot_count(11'd1025);
		send_cmd(make_cmd(OP_CLEAR, 0, 0, 1023));
		write_slot_count(11'd1);
		send_cmd(make_cmd(OP_FILL, 0, 2047, 0));
		send_cmd(make_cmd(OP_CLEAR, 1023, 0, 1023));
	endtask

	task automatic test_random_traffic(input int items, input int idle,
	                                   input logic [CNT_W-1:0] slots);
		write_slot_count(slots);
		idle_pct = idle;
		repeat (items) send_cmd(random_cmd());
	endtask

	task automatic test_pressure_pause();
		idle_pct = 0;
		repeat (10) send_cmd(random_cmd());
		drain_results();
		repeat (10) send_cmd(random_cmd());
	endtask

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$error("result transfer with no command outstanding");
				errors++;
			end else begin
				oldest_result = pending_results.pop_front();
				results_seen++;
				if (result.none_placed !== oldest_result.none_placed) begin
					$error("none_placed: expected %0d, got %0d",
					       oldest_result.none_placed, result.none_placed);
					errors++;
				end
				if (result.first_placed !== oldest_result.first_placed) begin
					$error("first_placed: expected %0d, got %0d",
					       oldest_result.first_placed, result.first_placed);
					errors++;
				end
				if (result.last_placed !== oldest_result.last_placed) begin
					$error("last_placed: expected %0d, got %0d",
					       oldest_result.last_placed, result.last_placed);
					errors++;
				end
				if (result.freed_count !== oldest_result.freed_count) begin
					$error("freed_count: expected %0d, got %0d",
					       oldest_result.freed_count, result.freed_count);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		if ((start && !busy) || done)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("tb: done, errors");
			$finish;
		end
	end

	initial begin
		arst_n         = 1'b0;
		start          = 1'b0;
		cmd            = '0;
		cfg_we         = 1'b0;
		cfg_wdata      = '0;
		slot_count_reg = 11'd1024;
		errors         = 0;
		fills_sent     = 0;
		clears_sent    = 0;
		results_seen   = 0;
		cfg_writes     = 0;
		idle_pct       = 0;
		quiet_cycles   = 0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		test_directed_ops();
		test_count_register();
		test_random_traffic(160, 0, 11'd1024);
		test_random_traffic(100, 52, 11'd37);
		test_random_traffic(120, 28, 11'd2047);
		test_random_traffic(100, 52, $urandom_range(2, 300));
		test_pressure_pause();

		drain_results();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (pending_results.size() != 0) begin
			$error("%0d results never arrived", pending_results.size());
			errors++;
		end
		$display("tb: %0d fills and %0d clears sent, %0d results checked",
		         fills_sent, clears_sent, results_seen);
		$display("tb: %0d slot count writes, sender idle ratios 0/28/52 percent",
		         cfg_writes);
		if (errors == 0)
			$display("tb: done, clean");
		else
			$display("tb: done, errors");
		$finish;
	end

endmodule

>>> slot_bitmap_fill_and_clear.f
rtl/sbfc_pkg.sv
rtl/sbfc_mem.sv
rtl/sbfc_word_op.sv
rtl/slot_bitmap_fill_and_clear.sv
tb/tb.sv
